@@ rtl/qdec_pkg.sv @@
// Package for the quadrature decoder: action codes, config indexes, step table,
// configuration struct and reset constants. No dependencies.
`timescale 1ns / 1ps

package qdec_pkg;

  localparam int unsigned CPR_W     = 16;
  localparam int unsigned HOLDOFF_W = 20;
  localparam int unsigned CFG_W     = 20;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned TIME_W    = 32;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_INDEX  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_PRIME  = 2'd3
  } action_e;

  typedef enum logic {
    CFG_COUNTS_PER_REV   = 1'b0,
    CFG_INDEX_HOLDOFF_US = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_FWD  = 2'd1,
    STEP_REV  = 2'd2
  } step_e;

  localparam logic [CPR_W-1:0]     CPR_RESET     = 16'd4096;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 20'd15000;
  localparam logic [CPR_W-1:0]     GATE_RESET    = 16'((4096 * 3) / 5);

  // floor(x / 5) = (x * GATE_RECIP) >> GATE_SHIFT, exact for x below 2^18
  localparam int unsigned   GATE_SHIFT = 20;
  localparam logic [17:0]   GATE_RECIP = 18'd209716;

  typedef struct packed {
    logic [CPR_W-1:0]     counts_per_rev;
    logic [HOLDOFF_W-1:0] holdoff_us;
    logic [CPR_W-1:0]     gate;
  } cfg_t;

  function automatic step_e step_lookup(input logic [1:0] last_ab, input logic [1:0] ab);
    step_e s;
    case ({last_ab, ab})
      4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_FWD;
      4'd2, 4'd4, 4'd11, 4'd13: s = STEP_REV;
      default:                  s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/qdec_if.sv @@
// Valid/ready channel interfaces for the quadrature decoder input and result words.
// Depends on qdec_pkg for field widths.
`timescale 1ns / 1ps

interface qdec_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [1:0]                    ab_state;
  logic [qdec_pkg::TIME_W-1:0]   now_us;

  modport source (output valid, action, ab_state, now_us, input ready);
  modport sink   (input valid, action, ab_state, now_us, output ready);
endinterface

interface qdec_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qdec_pkg::POS_W-1:0]  position;
  logic signed [qdec_pkg::POS_W-1:0]  revolutions;
  logic [qdec_pkg::CPR_W-1:0]         pulse_in_rev;
  logic                               dir_cw;
  logic                               index_taken;
  logic                               step_valid;

  modport source (output valid, position, revolutions, pulse_in_rev, dir_cw, index_taken,
                  step_valid, input ready);
  modport sink   (input valid, position, revolutions, pulse_in_rev, dir_cw, index_taken,
                  step_valid, output ready);
endinterface

@@ rtl/quadrature_decoder_with_index.sv @@
// Top level of the x4 quadrature decoder with index-pulse revolution tracking.
// Depends on qdec_pkg, qdec_if, qdec_cfg and qdec_core.
`timescale 1ns / 1ps

// Usage:
//   in_i carries one word per event: action (sample, index edge, clear, prime),
//   the A/B pin pair and a 32-bit microsecond timestamp.
//   out_o returns exactly one word per input word: position, revolutions,
//   pulse_in_rev, dir_cw, index_taken and step_valid as they stand after it.
//   The result is registered: a word accepted at one edge shows on out_o after it.
//   Throughput is one word per cycle; the decoder state feeds straight back
//   into the next word through one level of table lookup, adders and compares.
//   The result register holds one word; while it is full and out_o.ready is
//   low, in_i.ready drops and the state holds. A word can enter in the same
//   cycle the held result is taken.
//   cfg_we_i writes counts_per_rev (index 0) or index_holdoff_us (index 1);
//   the index gate of counts_per_rev * 3 / 5 is computed at the write.
//   Write configuration only while no result is pending.
//   Reset clears all counts, sets direction to clockwise, empties the result
//   register and loads counts_per_rev 4096 and a holdoff of 15000 us.
module quadrature_decoder_with_index (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [qdec_pkg::CFG_W-1:0]  cfg_wdata_i,
  qdec_in_if.sink                     in_i,
  qdec_out_if.source                  out_o
);

  qdec_pkg::cfg_t cfg;

  qdec_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  qdec_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

@@ rtl/qdec_cfg.sv @@
// Configuration registers and the precomputed index gate (counts_per_rev * 3 / 5).
// Depends on qdec_pkg.
`timescale 1ns / 1ps

module qdec_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [qdec_pkg::CFG_W-1:0]    cfg_wdata_i,
  output qdec_pkg::cfg_t                cfg_o
);

  qdec_pkg::cfg_t cfg_q, cfg_d;
  logic [17:0]    triple;
  logic [35:0]    prod;

  always_comb begin
    triple = {2'b00, cfg_wdata_i[15:0]} + {1'b0, cfg_wdata_i[15:0], 1'b0};
    prod   = {18'd0, triple} * {18'd0, qdec_pkg::GATE_RECIP};
    cfg_d  = cfg_q;
    if (cfg_we_i) begin
      case (qdec_pkg::cfg_index_e'(cfg_index_i))
        qdec_pkg::CFG_COUNTS_PER_REV: begin
          cfg_d.counts_per_rev = cfg_wdata_i[qdec_pkg::CPR_W-1:0];
          cfg_d.gate = prod[qdec_pkg::GATE_SHIFT +: qdec_pkg::CPR_W];
        end
        qdec_pkg::CFG_INDEX_HOLDOFF_US: begin
          cfg_d.holdoff_us = cfg_wdata_i[qdec_pkg::HOLDOFF_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counts_per_rev <= qdec_pkg::CPR_RESET;
      cfg_q.holdoff_us     <= qdec_pkg::HOLDOFF_RESET;
      cfg_q.gate           <= qdec_pkg::GATE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/qdec_core.sv @@
// Decoder state, per-word update logic and the result register.
// Depends on qdec_pkg, qdec_if and the configuration from qdec_cfg.
`timescale 1ns / 1ps

module qdec_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qdec_pkg::cfg_t cfg_i,
  qdec_in_if.sink        in_i,
  qdec_out_if.source     out_o
);

  logic [1:0]                    last_ab_q, last_ab_d;
  logic [qdec_pkg::POS_W-1:0]    position_q, position_d;
  logic [qdec_pkg::POS_W-1:0]    revs_q, revs_d;
  logic [qdec_pkg::CPR_W-1:0]    pulse_q, pulse_d;
  logic                          dir_q, dir_d;
  logic [qdec_pkg::POS_W-1:0]    index_pos_q, index_pos_d;
  logic [qdec_pkg::TIME_W-1:0]   index_time_q, index_time_d;

  logic                          out_valid_q;
  logic                          taken_q, taken_d;
  logic                          step_q, step_d;

  logic                          accept;
  qdec_pkg::step_e               step;
  logic [qdec_pkg::CPR_W-1:0]    pulse_inc;
  logic [qdec_pkg::TIME_W-1:0]   elapsed;
  logic [qdec_pkg::POS_W-1:0]    diff;
  logic [qdec_pkg::POS_W-1:0]    distance;
  logic                          holdoff_ok;
  logic                          gate_ok;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    step       = qdec_pkg::step_lookup(last_ab_q, in_i.ab_state);
    pulse_inc  = pulse_q + 16'd1;
    elapsed    = in_i.now_us - index_time_q;
    diff       = position_q - index_pos_q;
    distance   = diff[qdec_pkg::POS_W-1] ? (32'd0 - diff) : diff;
    holdoff_ok = elapsed >= {12'd0, cfg_i.holdoff_us};
    gate_ok    = distance >= {16'd0, cfg_i.gate};

    last_ab_d    = last_ab_q;
    position_d   = position_q;
    revs_d       = revs_q;
    pulse_d      = pulse_q;
    dir_d        = dir_q;
    index_pos_d  = index_pos_q;
    index_time_d = index_time_q;
    taken_d      = 1'b0;
    step_d       = 1'b0;

    case (qdec_pkg::action_e'(in_i.action))
      qdec_pkg::ACT_SAMPLE: begin
        last_ab_d = in_i.ab_state;
        if (step != qdec_pkg::STEP_NONE) begin
          step_d     = 1'b1;
          dir_d      = (step == qdec_pkg::STEP_FWD);
          position_d = (step == qdec_pkg::STEP_FWD) ? position_q + 32'd1 : position_q - 32'd1;
          pulse_d    = (pulse_inc >= cfg_i.counts_per_rev) ? '0 : pulse_inc;
        end
      end
      qdec_pkg::ACT_INDEX: begin
        if (holdoff_ok && gate_ok) begin
          taken_d      = 1'b1;
          index_pos_d  = position_q;
          index_time_d = in_i.now_us;
          pulse_d      = '0;
          revs_d       = dir_q ? revs_q + 32'd1 : revs_q - 32'd1;
        end
      end
      qdec_pkg::ACT_CLEAR: begin
        position_d = '0;
        revs_d     = '0;
        pulse_d    = '0;
      end
      qdec_pkg::ACT_PRIME: begin
        last_ab_d = in_i.ab_state;
      end
      default: begin
        last_ab_d = last_ab_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ab_q    <= '0;
      position_q   <= '0;
      revs_q       <= '0;
      pulse_q      <= '0;
      dir_q        <= 1'b1;
      index_pos_q  <= '0;
      index_time_q <= '0;
      out_valid_q  <= 1'b0;
      taken_q      <= 1'b0;
      step_q       <= 1'b0;
    end else begin
      if (accept) begin
        last_ab_q    <= last_ab_d;
        position_q   <= position_d;
        revs_q       <= revs_d;
        pulse_q      <= pulse_d;
        dir_q        <= dir_d;
        index_pos_q  <= index_pos_d;
        index_time_q <= index_time_d;
        out_valid_q  <= 1'b1;
        taken_q      <= taken_d;
        step_q       <= step_d;
      end else if (out_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.position     = position_q;
  assign out_o.revolutions  = revs_q;
  assign out_o.pulse_in_rev = pulse_q;
  assign out_o.dir_cw       = dir_q;
  assign out_o.index_taken  = taken_q;
  assign out_o.step_valid   = step_q;

`ifndef NO_ASSERTIONS
  a_taken_xor_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(taken_q && step_q))
    else $error("index and step flagged on one word");

  a_index_clears_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && taken_q) |-> (pulse_q == '0))
    else $error("accepted index left pulse count nonzero");

  a_pulse_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && step_q) |-> (pulse_q == '0 || pulse_q < cfg_i.counts_per_rev))
    else $error("pulse count past wrap point");

  a_step_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && step_d) |=> (position_q != $past(position_q)))
    else $error("valid step did not move position");
`endif

endmodule
